// ===== hdl/oaht_pkg.sv =====
// ============================================================================
// oaht_pkg - shared types and constants for the open addressing hash table
// Request and response payloads, request and status codes, sequencer states.
// ============================================================================
package oaht_pkg;

    // Fixed field widths
    localparam int KEY_W   = 64;
    localparam int IDX_W   = 7;
    localparam int STEP_W  = 7;
    localparam int PROBE_W = 8;
    localparam int TOTAL_W = 20;

    // Width of the home-slot byte sum and of current slot plus step offset
    localparam int SUM_W    = 11;
    localparam int HASH_MAX = 2040;   // eight bytes of 255
    localparam int STEP_MAX = 127;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_SEARCH = 2'd1;
    localparam logic [1:0] REQ_LOAD   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_REJECT    = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [KEY_W-1:0]  key;
        logic [IDX_W-1:0]  step_index;
        logic [STEP_W-1:0] step_value;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [IDX_W-1:0]   slot_index;
        logic [PROBE_W-1:0] probe_count;
        logic [TOTAL_W-1:0] total_probes;
    } t_rsp;

    // Request to the shared modulo unit; wide selects the hash range
    typedef struct packed {
        logic             start;
        logic             wide;
        logic [SUM_W-1:0] value;
    } t_mod_req;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_RDKEY,
        ST_CHECK,
        ST_DONE
    } t_state;

endpackage

// ===== hdl/oaht_ram.sv =====
// ============================================================================
// oaht_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/oaht_mod.sv =====
// ============================================================================
// oaht_mod - shared modulo-table-size reduction unit
// Restoring conditional subtract of TABLE_SLOTS shifted left, one shift per
// cycle, stopping as soon as the remainder is below TABLE_SLOTS.
// ============================================================================
module oaht_mod #(
    parameter int TABLE_SLOTS = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  oaht_pkg::t_mod_req             i_req,
    output logic                           o_busy,
    output logic                           o_done,
    output logic [$clog2(TABLE_SLOTS)-1:0] o_result
);
    import oaht_pkg::*;

    localparam int IW   = $clog2(TABLE_SLOTS);
    localparam int SH_W = 4;

    // Largest shift whose shifted table size still fits under limit
    function automatic int kmax(input int limit);
        int k;
        int j;
        k = 0;
        for (j = 0; j < SUM_W; j++) begin
            if ((TABLE_SLOTS << j) <= limit) begin
                k = j;
            end
        end
        return k;
    endfunction

    localparam int K_HASH = kmax(HASH_MAX);
    localparam int K_STEP = kmax(TABLE_SLOTS - 1 + STEP_MAX);

    logic             r_busy;
    logic [SUM_W-1:0] r_val;
    logic [SH_W-1:0]  r_k;
    logic [SUM_W-1:0] lim;
    logic [SUM_W-1:0] sub;

    // One conditional subtract per cycle
    always_comb begin
        lim      = SUM_W'(TABLE_SLOTS) << r_k;
        sub      = (r_val >= lim) ? (r_val - lim) : r_val;
        o_done   = r_busy && ((r_k == '0) || (sub < SUM_W'(TABLE_SLOTS)));
        o_result = sub[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_val  <= i_req.value;
            r_k    <= i_req.wide ? SH_W'(K_HASH) : SH_W'(K_STEP);
        end else if (r_busy) begin
            r_val <= sub;
            r_k   <= r_k - 1'b1;
            if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;

endmodule

// ===== hdl/open_addressing_hash_table.sv =====
// ============================================================================
// open_addressing_hash_table - hash table with pseudo-random step probing
// Insert, search and probe-step load requests, one at a time.
// ============================================================================
// After reset the key store is swept to empty, one slot per cycle, and the
// block takes no request until the sweep is done. An insert or search first
// reduces the key's byte sum to its home slot in the shared modulo unit, then
// each probe reads the key store and compares the slot; when probing goes on,
// the modulo unit reduces current slot plus step to the next slot. Load and
// rejected requests go straight to the done state. A finished response sits
// in an output register, and the next request is taken while it waits.
module open_addressing_hash_table #(
    parameter int TABLE_SLOTS = 128,
    parameter int KEY_BYTES   = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  oaht_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output oaht_pkg::t_rsp  o_rsp
);
    import oaht_pkg::*;

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int NW = $clog2(TABLE_SLOTS + 1);
    localparam int KW = 8 * KEY_BYTES;
    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_BYTES >= 8) ? '1 : ((KEY_W'(1) << (8 * KEY_BYTES)) - KEY_W'(1));

    t_state              r_state, n_state;
    logic [IW-1:0]       r_clr;
    logic [IW-1:0]       r_idx;
    logic [NW-1:0]       r_n;
    logic [KEY_W-1:0]    r_key;
    logic                r_is_insert;
    logic [TOTAL_W-1:0]  r_total;
    logic [1:0]          r_status;
    logic [IW-1:0]       r_slot;
    logic [NW:0]         r_probes;
    logic                r_rsp_valid;
    t_rsp                r_rsp;

    logic [KEY_W-1:0]    key_masked;
    logic [SUM_W-1:0]    hash_sum;
    logic                req_load;
    logic                req_reject;
    logic                step_in_range;

    logic                key_we;
    logic [IW-1:0]       key_waddr;
    logic [KW-1:0]       key_wdata;
    logic [IW-1:0]       key_raddr;
    logic [KW-1:0]       key_rd;
    logic                step_we;
    logic [IW-1:0]       step_waddr;
    logic [STEP_W-1:0]   step_wdata;
    logic [IW-1:0]       step_raddr;
    logic [STEP_W-1:0]   step_rd;

    t_mod_req            mod_req;
    logic                mod_busy;
    logic                mod_done;
    logic [IW-1:0]       mod_result;

    logic                key_empty;
    logic                key_match;
    logic                at_limit;
    logic                probe_end;
    logic [1:0]          chk_status;
    logic [IW-1:0]       chk_slot;
    logic [NW:0]         probes;
    logic [TOTAL_W:0]    total_sum;
    logic [TOTAL_W-1:0]  total_next;
    logic                out_free;

    // Request decode and byte-sum hash
    always_comb begin
        key_masked = i_req.key & KEY_MASK;
        hash_sum   = '0;
        for (int b = 0; b < 8; b++) begin
            hash_sum = hash_sum + SUM_W'(key_masked[8*b +: 8]);
        end
        req_load      = (i_req.req_type == REQ_LOAD);
        req_reject    = (i_req.req_type == REQ_UNUSED) || (key_masked == '0);
        step_in_range = (SUM_W'(i_req.step_index) < SUM_W'(TABLE_SLOTS));
    end

    // Probe evaluation on the slot just read
    always_comb begin
        key_empty = (key_rd == '0);
        key_match = (key_rd == r_key[KW-1:0]);
        at_limit  = (r_n == NW'(TABLE_SLOTS));
        if (r_is_insert) begin
            probe_end  = key_empty || at_limit;
            chk_status = key_empty ? STAT_OK : STAT_FULL;
            chk_slot   = key_empty ? r_idx : '0;
        end else begin
            probe_end  = key_match || key_empty || at_limit;
            chk_status = key_match ? STAT_OK : STAT_NOT_FOUND;
            chk_slot   = key_match ? r_idx : '0;
        end
        probes     = (NW + 1)'(r_n) + 1'b1;
        total_sum  = (TOTAL_W + 1)'(r_total) + (TOTAL_W + 1)'(probes);
        total_next = (total_sum > (TOTAL_W + 1)'(TOTAL_MAX)) ? TOTAL_MAX
                                                             : total_sum[TOTAL_W-1:0];
        out_free   = !r_rsp_valid || i_rsp_ready;
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == IW'(TABLE_SLOTS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_req_valid) n_state = (req_load || req_reject) ? ST_DONE : ST_MOD;
            end
            ST_MOD: begin
                if (mod_done) n_state = ST_RDKEY;
            end
            ST_RDKEY: n_state = ST_CHECK;
            ST_CHECK: n_state = probe_end ? ST_DONE : ST_MOD;
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Sequencer outputs: memory ports and modulo unit requests
    always_comb begin
        key_we     = 1'b0;
        key_waddr  = r_idx;
        key_wdata  = r_key[KW-1:0];
        key_raddr  = r_idx;
        step_we    = 1'b0;
        step_waddr = IW'(i_req.step_index);
        step_wdata = i_req.step_value;
        step_raddr = r_n[IW-1:0];
        mod_req    = '0;
        unique case (r_state)
            ST_CLEAR: begin
                key_we    = 1'b1;
                key_waddr = r_clr;
                key_wdata = '0;
            end
            ST_IDLE: begin
                if (i_req_valid) begin
                    if (req_load) begin
                        step_we = step_in_range;
                    end else if (!req_reject) begin
                        mod_req.start = 1'b1;
                        mod_req.wide  = 1'b1;
                        mod_req.value = hash_sum;
                    end
                end
            end
            ST_CHECK: begin
                key_we = r_is_insert && key_empty;
                if (!probe_end) begin
                    mod_req.start = 1'b1;
                    mod_req.wide  = 1'b0;
                    mod_req.value = SUM_W'(r_idx) + SUM_W'(step_rd);
                end
            end
            default: ;
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_total     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            // capture a new request
            if (r_state == ST_IDLE && i_req_valid) begin
                r_is_insert <= (i_req.req_type == REQ_INSERT);
                r_key       <= key_masked;
                r_n         <= '0;
                r_status    <= req_load ? STAT_OK : STAT_REJECT;
                r_slot      <= '0;
                r_probes    <= '0;
            end
            if (r_state == ST_MOD && mod_done) begin
                r_idx <= mod_result;
            end
            // finish or take one more step
            if (r_state == ST_CHECK) begin
                if (probe_end) begin
                    r_status <= chk_status;
                    r_slot   <= chk_slot;
                    r_probes <= probes;
                    if (r_is_insert) r_total <= total_next;
                end else begin
                    r_n <= r_n + 1'b1;
                end
            end
            // response register
            if (r_state == ST_DONE && out_free) begin
                r_rsp_valid        <= 1'b1;
                r_rsp.status       <= r_status;
                r_rsp.slot_index   <= IDX_W'(r_slot);
                r_rsp.probe_count  <= PROBE_W'(r_probes);
                r_rsp.total_probes <= r_total;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    oaht_ram #(
        .WIDTH (KW),
        .DEPTH (TABLE_SLOTS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_raddr (key_raddr),
        .o_rdata (key_rd)
    );

    oaht_ram #(
        .WIDTH (STEP_W),
        .DEPTH (TABLE_SLOTS)
    ) u_step_ram (
        .i_clk   (i_clk),
        .i_we    (step_we),
        .i_waddr (step_waddr),
        .i_wdata (step_wdata),
        .i_raddr (step_raddr),
        .o_rdata (step_rd)
    );

    oaht_mod #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mod_req),
        .o_busy   (mod_busy),
        .o_done   (mod_done),
        .o_result (mod_result)
    );

`ifndef SYNTHESIS
    // The modulo unit is free whenever a request is taken
    a_mod_idle_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |-> !mod_busy)
        else $error("modulo unit busy at request accept");

    // Step count never passes the table size
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |-> (r_n <= NW'(TABLE_SLOTS)))
        else $error("probe step count out of range");

    // Running total never goes down
    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_total >= $past(r_total)))
        else $error("insert probe total decreased");

    // A response only appears out of the done state
    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> ($past(r_state) == ST_DONE))
        else $error("response raised outside done state");
`endif

endmodule

// ===== test/hash_table_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// hash_table_checker - response predictor for the open addressing hash table
// Watches both channels, keeps its own slot store, probe step table and
// insert probe total, and compares every response against the prediction.
// ============================================================================
module hash_table_checker #(
    parameter int TABLE_SLOTS = 128,
    parameter int KEY_BYTES   = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_ready,
    input  oaht_pkg::t_req i_req,
    input  logic           i_rsp_valid,
    input  logic           i_rsp_ready,
    input  oaht_pkg::t_rsp i_rsp,
    output int             o_mismatches,
    output int             o_outstanding
);
    import oaht_pkg::*;

    logic [KEY_W-1:0]   slot_store [TABLE_SLOTS];
    logic [STEP_W-1:0]  step_table [TABLE_SLOTS];
    logic [TOTAL_W-1:0] insert_probe_total;
    t_rsp               expected_rsps [$];

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
        // never read before a load writes it
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            step_table[i] = '0;
        end
    end

    // One line per mismatch
    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        o_mismatches++;
    endtask

    // Bytes above KEY_BYTES are dropped for hashing and storage
    function automatic logic [KEY_W-1:0] mask_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            m[8*i +: 8] = 8'hFF;
        end
        return k & m;
    endfunction

    // Unsigned byte sum modulo the slot count
    function automatic int unsigned home_slot_of(input logic [KEY_W-1:0] k);
        int unsigned byte_sum;
        byte_sum = 0;
        for (int i = 0; i < 8; i++) begin
            byte_sum += 32'(k[8*i +: 8]);
        end
        return byte_sum % TABLE_SLOTS;
    endfunction

    // Apply one request to the shadow state and build its response
    task automatic predict_response(input t_req r, output t_rsp rsp);
        logic [KEY_W-1:0] k;
        int unsigned      idx;
        int unsigned      steps;
        int unsigned      sum_total;
        bit               done;
        k   = mask_key(r.key);
        rsp = '0;
        if (r.req_type == REQ_LOAD) begin
            if (r.step_index < TABLE_SLOTS) begin
                step_table[r.step_index] = r.step_value;
            end
        end else if (r.req_type == REQ_UNUSED || k == '0) begin
            rsp.status = STAT_REJECT;
        end else begin
            idx   = home_slot_of(k);
            steps = 0;
            done  = 1'b0;
            if (r.req_type == REQ_INSERT) begin
                // first empty slot wins, give up after a full round of steps
                while (!done) begin
                    if (slot_store[idx] == '0) begin
                        slot_store[idx] = k;
                        rsp.slot_index  = IDX_W'(idx);
                        done            = 1'b1;
                    end else if (steps >= TABLE_SLOTS) begin
                        rsp.status = STAT_FULL;
                        done       = 1'b1;
                    end else begin
                        idx = (idx + step_table[steps]) % TABLE_SLOTS;
                        steps++;
                    end
                end
                sum_total = insert_probe_total + steps + 1;
                insert_probe_total = (sum_total > TOTAL_MAX) ? TOTAL_MAX
                                                             : TOTAL_W'(sum_total);
            end else begin
                // stop on the key, an empty slot, or the step limit
                while (!done) begin
                    if (slot_store[idx] == k) begin
                        rsp.slot_index = IDX_W'(idx);
                        done           = 1'b1;
                    end else if (slot_store[idx] == '0 || steps >= TABLE_SLOTS) begin
                        rsp.status = STAT_NOT_FOUND;
                        done       = 1'b1;
                    end else begin
                        idx = (idx + step_table[steps]) % TABLE_SLOTS;
                        steps++;
                    end
                end
            end
            rsp.probe_count = PROBE_W'(steps + 1);
        end
        rsp.total_probes = insert_probe_total;
    endtask

    // Responses are retired before the same edge's request is predicted
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                slot_store[i] = '0;
            end
            insert_probe_total = '0;
            expected_rsps.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                got = i_rsp;
                if (expected_rsps.size() == 0) begin
                    report_mismatch($sformatf("response with no request pending: %h", got));
                end else begin
                    want = expected_rsps.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                            got.status, want.status));
                    if (got.slot_index !== want.slot_index)
                        report_mismatch($sformatf("slot_index got %0d expected %0d",
                            got.slot_index, want.slot_index));
                    if (got.probe_count !== want.probe_count)
                        report_mismatch($sformatf("probe_count got %0d expected %0d",
                            got.probe_count, want.probe_count));
                    if (got.total_probes !== want.total_probes)
                        report_mismatch($sformatf("total_probes got %0d expected %0d",
                            got.total_probes, want.total_probes));
                end
            end
            if (i_req_valid && i_req_ready) begin
                predict_response(i_req, want);
                expected_rsps.push_back(want);
            end
        end
        o_outstanding = expected_rsps.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench - stimulus and verdict for the open addressing hash table
// Loads the probe step table, runs directed and random insert, search and
// load requests, plus rejected ones, with random idling on both sides, and reports the outcome.
// ============================================================================
module testbench;
    import oaht_pkg::*;

    localparam int      TABLE_SLOTS  = 128;
    localparam int      KEY_BYTES    = 8;
    localparam int      RANDOM_REQS  = 804;
    localparam int      HOLD_CYCLES  = 400;
    localparam int      HOLD_AFTER   = 60;
    localparam int      DRAIN_CYCLES = 600;
    localparam longint  LIMIT_NS     = 40_000_000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    t_req req;
    logic rsp_valid;
    logic rsp_ready;
    t_rsp rsp;

    int mismatches;
    int outstanding;
    int rsp_seen;
    int sender_calm;

    logic [KEY_W-1:0] placed_keys [$];

    open_addressing_hash_table #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BYTES   (KEY_BYTES)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp)
    );

    hash_table_checker #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BYTES   (KEY_BYTES)
    ) response_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_req         (req),
        .i_rsp_valid   (rsp_valid),
        .i_rsp_ready   (rsp_ready),
        .i_rsp         (rsp),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Accepted responses, used to time the long receiver hold-off
    initial rsp_seen = 0;
    always @(posedge clk) begin
        if (rst_n && rsp_valid && rsp_ready) begin
            rsp_seen <= rsp_seen + 1;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return $urandom_range(1, 2);
        if (pick < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_req make_request(input logic [1:0] kind,
                                          input logic [KEY_W-1:0] k);
        t_req r;
        r.req_type   = kind;
        r.key        = k;
        r.step_index = IDX_W'($urandom_range(0, 127));
        r.step_value = STEP_W'($urandom_range(0, 127));
        return r;
    endfunction

    function automatic t_req make_load(input int index, input int value);
        t_req r;
        r            = make_request(REQ_LOAD, {$urandom, $urandom});
        r.step_index = IDX_W'(index);
        r.step_value = STEP_W'(value);
        return r;
    endfunction

    // Wide random keys, or one or two live bytes to crowd the home slots
    function automatic logic [KEY_W-1:0] random_key();
        int               pick;
        logic [KEY_W-1:0] k;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            k = {$urandom, $urandom};
        end else begin
            k = '0;
            k[8*$urandom_range(0, 7) +: 8] = 8'($urandom_range(1, 255));
            if (pick < 75) k[8*$urandom_range(0, 7) +: 8] = 8'($urandom_range(0, 255));
        end
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] known_key();
        if (placed_keys.size() == 0) return random_key();
        return placed_keys[$urandom_range(0, placed_keys.size() - 1)];
    endfunction

    // Offer one request, hold it until taken, then maybe idle
    task automatic send_request(input t_req r);
        int gap;
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= r;
        if (r.req_type == REQ_INSERT && r.key != '0) placed_keys.push_back(r.key);
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        gap = 0;
        if (sender_calm > 0) begin
            sender_calm--;
        end else begin
            if ($urandom_range(0, 99) < 40) gap = idle_gap();
            if ($urandom_range(0, 99) == 0) sender_calm = $urandom_range(30, 120);
        end
        if (gap > 0) begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Reset, stimulus and verdict
    initial begin
        int               pick;
        logic [KEY_W-1:0] k;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        sender_calm = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // every step entry is written before any probe can read it
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            send_request(make_load(i, $urandom_range(0, 127)));
        end

        // directed requests
        send_request(make_request(REQ_INSERT, '0));                     // zero key
        send_request(make_request(REQ_SEARCH, '0));
        send_request(make_request(REQ_UNUSED, 64'h0000_0000_0000_00A5)); // unused type
        send_request(make_request(REQ_UNUSED, '0));
        send_request(make_request(REQ_SEARCH, 64'h1));                  // empty home slot
        send_request(make_request(REQ_INSERT, '1));                     // largest byte sum
        send_request(make_request(REQ_INSERT, '1));                     // duplicate insert
        send_request(make_request(REQ_SEARCH, '1));
        send_request(make_request(REQ_INSERT, 64'h1));
        send_request(make_request(REQ_INSERT, 64'h100));                // same home as 1
        send_request(make_request(REQ_INSERT, 64'h8000_0000_0000_0000));
        send_request(make_request(REQ_SEARCH, 64'h100));
        send_request(make_request(REQ_SEARCH, 64'h1_0000));             // collides, absent
        send_request(make_request(REQ_INSERT, 64'h7F));
        send_request(make_request(REQ_INSERT, 64'h0101_0101_0101_0101));
        send_request(make_load(127, 127));                               // step extremes
        send_request(make_load(0, 0));
        send_request(make_request(REQ_SEARCH, 64'h0101_0101_0101_0101));

        // random traffic, mostly inserts and searches, the searches mostly of live keys
        for (int n = 0; n < RANDOM_REQS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                k = ($urandom_range(0, 3) == 0) ? known_key() : random_key();
                send_request(make_request(REQ_INSERT, k));
            end else if (pick < 80) begin
                k = ($urandom_range(0, 99) < 65) ? known_key() : random_key();
                send_request(make_request(REQ_SEARCH, k));
            end else if (pick < 88) begin
                send_request(make_load($urandom_range(0, 127), $urandom_range(0, 127)));
            end else if (pick < 94) begin
                send_request(make_request($urandom_range(0, 1) ? REQ_SEARCH : REQ_INSERT,
                                          '0));
            end else begin
                send_request(make_request(REQ_UNUSED, random_key()));
            end
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Response side: random stalls, calm stretches, one long hold-off
    initial begin
        int  stall_left;
        int  calm_left;
        int  hold_left;
        bit  held_off;
        rsp_ready  = 1'b0;
        stall_left = 0;
        calm_left  = 0;
        hold_left  = 0;
        held_off   = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                hold_left--;
                rsp_ready <= 1'b0;
            end else if (!held_off && rsp_seen >= HOLD_AFTER) begin
                held_off  = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                rsp_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                end else begin
                    if ($urandom_range(0, 99) < 30) stall_left = idle_gap();
                    if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(50, 200);
                end
            end
        end
    end

    // Hard stop
    initial begin
        #(LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
